// ----- rtl/cl4_pkg.sv -----
// Shared types and constants for the 4-bit character LCD controller.
// Used by every module of the block except cl4_fifo; depends on nothing else.
package cl4_pkg;

  // Display geometry used for cursor clamping and row base addresses.
  localparam int COLUMNS = 20;
  localparam int ROWS    = 4;

  // Default depth of the request and result queues.
  localparam int QUEUE_DEPTH = 2;

  // Power-up sequence: four bare nibbles, then five instruction bytes.
  localparam logic [3:0] INIT_NIBBLES = 4'd4;
  localparam logic [3:0] INIT_DONE    = 4'd9;

  // Configuration register indexes.
  localparam logic [2:0] REG_SETUP      = 3'd0;
  localparam logic [2:0] REG_BYTE_GAP   = 3'd1;
  localparam logic [2:0] REG_FIRST_INIT = 3'd2;
  localparam logic [2:0] REG_INIT_GAP   = 3'd3;
  localparam logic [2:0] REG_MOVE_GAP   = 3'd4;

  typedef enum logic [1:0] {
    OP_DATA  = 2'd0,
    OP_INSTR = 2'd1,
    OP_MOVE  = 2'd2,
    OP_CLEAR = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    GAP_NONE = 2'd0,
    GAP_INIT = 2'd1,
    GAP_MOVE = 2'd2
  } post_gap_t;

  typedef enum logic [3:0] {
    PH_START    = 4'd0,
    PH_PRE      = 4'd1,
    PH_SETUP_HI = 4'd2,
    PH_PULSE_HI = 4'd3,
    PH_SETUP_LO = 4'd4,
    PH_PULSE_LO = 4'd5,
    PH_GAP1     = 4'd6,
    PH_GAP2     = 4'd7,
    PH_IDLE     = 4'd8
  } phase_t;

  // One input request as it arrives on the push side.
  typedef struct packed {
    logic       tick;
    logic       cmd_valid;
    logic [1:0] opcode;
    logic [7:0] byte_value;
    logic [4:0] column;
    logic [2:0] row;
  } in_item_t;

  // One result as it leaves on the pop side.
  typedef struct packed {
    logic       rs_pin;
    logic       en_pin;
    logic [3:0] data_nibble;
    logic       ready_res;
    logic       accepted;
  } res_item_t;

  // A classified request, ready for the sequencer.
  typedef struct packed {
    logic       tick;
    logic       cmd_valid;
    logic [7:0] byte_value;
    logic       rs;
    post_gap_t  post;
  } job_t;

  // Timing registers.
  typedef struct packed {
    logic [15:0] setup_ticks;
    logic [15:0] byte_gap_ticks;
    logic [15:0] first_init_gap;
    logic [15:0] init_gap_ticks;
    logic [15:0] move_gap_ticks;
  } cfg_t;

endpackage

// ----- rtl/char_lcd_4bit_interface.sv -----
// A request is registered in the job queue, its result then in the result queue.
// Throughput: one request per clock while the result queue has room; the sequencer
// finishes one per cycle, its path bounded by the wait counter add and compare.
// Reset (rst, synchronous, active high) empties both queues, loads the default timing
// and restarts the power-up sequence with the first request after reset.
// Depends on cl4_pkg, cl4_fifo, cl4_front and cl4_seq.
module char_lcd_4bit_interface #(
  parameter int QUEUE_DEPTH = cl4_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  // Request side: a request is taken when push is high and full is low.
  input  logic               push,
  input  cl4_pkg::in_item_t  item,
  output logic               full,
  // Result side: the oldest result stands on result while empty is low.
  input  logic               pop,
  output cl4_pkg::res_item_t result,
  output logic               empty,
  // Timing register writes, taken whenever cfg_we is high.
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);
  import cl4_pkg::*;

  // The front end classifies each request (data, instruction, cursor move
  // or clear) into the byte to send and queues it. The sequencer drains that
  // queue one request per cycle whenever the result queue has room, so a
  // stalled consumer backs up into the job queue and then raises full.

  cfg_t      cfg;
  job_t      job;
  logic      job_empty;
  logic      job_pop;
  logic      res_full;
  logic      res_push;
  res_item_t res;

  // Timing registers. Writes beyond the last register are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.setup_ticks    <= 16'd100;
      cfg.byte_gap_ticks <= 16'd2000;
      cfg.first_init_gap <= 16'd5000;
      cfg.init_gap_ticks <= 16'd1000;
      cfg.move_gap_ticks <= 16'd2000;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SETUP:      cfg.setup_ticks    <= cfg_data;
        REG_BYTE_GAP:   cfg.byte_gap_ticks <= cfg_data;
        REG_FIRST_INIT: cfg.first_init_gap <= cfg_data;
        REG_INIT_GAP:   cfg.init_gap_ticks <= cfg_data;
        REG_MOVE_GAP:   cfg.move_gap_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  cl4_front #(
    .DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .item     (item),
    .full     (full),
    .job_pop  (job_pop),
    .job      (job),
    .job_empty(job_empty)
  );

  // The sequencer owns all bus timing: setup and pulse widths, byte gaps
  // and the power-up waits, each counted in ticks carried by requests.
  cl4_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .job      (job),
    .job_empty(job_empty),
    .job_pop  (job_pop),
    .res_full (res_full),
    .res_push (res_push),
    .res      (res)
  );

  // Result queue; it parts the sequencer from the consumer.
  cl4_fifo #(
    .WIDTH($bits(res_item_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_res_q (
    .clk    (clk),
    .rst    (rst),
    .push   (res_push),
    .wr_data(res),
    .full   (res_full),
    .pop    (pop),
    .rd_data(result),
    .empty  (empty)
  );

endmodule

// ----- rtl/cl4_fifo.sv -----
// Small register-based first-in first-out queue.
// Generic over width and depth; no package dependency.
module cl4_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             push_ok;
  logic             pop_ok;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign push_ok = push && !full;
  assign pop_ok  = pop && !empty;
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push_ok) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop_ok) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push_ok && !pop_ok) begin
        count <= count + 1'b1;
      end else if (pop_ok && !push_ok) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("queue count exceeds depth");

  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (push_ok && !pop_ok) |=> (count == $past(count) + 1'b1))
    else $error("queue count did not grow on push");

  a_ptr_sync: assert property (@(posedge clk) disable iff (rst)
    (count == '0 || count == CW'(DEPTH)) |-> (wr_ptr == rd_ptr))
    else $error("queue pointers disagree with count");

endmodule

// ----- rtl/cl4_front.sv -----
// Front end: takes requests, turns each into the byte, register select and
// trailing gap to send, and queues it. Depends on cl4_pkg and cl4_fifo.
module cl4_front #(
  parameter int DEPTH = cl4_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  cl4_pkg::in_item_t item,
  output logic              full,
  input  logic              job_pop,
  output cl4_pkg::job_t     job,
  output logic              job_empty
);
  import cl4_pkg::*;

  logic [5:0] col_c;
  logic [2:0] row_c;
  logic [6:0] base;
  logic [6:0] addr;
  logic [7:0] move_cmd;
  job_t       job_in;

  // Clamp the cursor target into the visible area, then form the
  // set-DDRAM-address command from the row base.
  always_comb begin
    if (item.column == 5'd0) begin
      col_c = 6'd1;
    end else if ({1'b0, item.column} > 6'(COLUMNS)) begin
      col_c = 6'(COLUMNS);
    end else begin
      col_c = {1'b0, item.column};
    end
    if (item.row == 3'd0) begin
      row_c = 3'd1;
    end else if (item.row > 3'(ROWS)) begin
      row_c = 3'(ROWS);
    end else begin
      row_c = item.row;
    end
    case (row_c)
      3'd1:    base = 7'h00;
      3'd2:    base = 7'h40;
      3'd3:    base = 7'(COLUMNS);
      default: base = 7'(7'h40 + COLUMNS);
    endcase
    addr     = base + 7'(col_c) - 7'd1;
    move_cmd = 8'h80 | {1'b0, addr};
  end

  always_comb begin
    job_in.tick      = item.tick;
    job_in.cmd_valid = item.cmd_valid;
    case (opcode_t'(item.opcode))
      OP_DATA: begin
        job_in.byte_value = item.byte_value;
        job_in.rs         = 1'b1;
        job_in.post       = GAP_NONE;
      end
      OP_INSTR: begin
        job_in.byte_value = item.byte_value;
        job_in.rs         = 1'b0;
        job_in.post       = GAP_NONE;
      end
      OP_MOVE: begin
        job_in.byte_value = move_cmd;
        job_in.rs         = 1'b0;
        job_in.post       = GAP_MOVE;
      end
      default: begin
        job_in.byte_value = 8'h01;
        job_in.rs         = 1'b0;
        job_in.post       = GAP_MOVE;
      end
    endcase
  end

  cl4_fifo #(
    .WIDTH($bits(job_t)),
    .DEPTH(DEPTH)
  ) u_job_q (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_data(job_in),
    .full   (full),
    .pop    (job_pop),
    .rd_data(job),
    .empty  (job_empty)
  );

endmodule

// ----- rtl/cl4_seq.sv -----
// Back end: the bus sequencer. Runs the power-up sequence and the nibble
// transfers, one queued request per step. Depends on cl4_pkg.
module cl4_seq (
  input  logic               clk,
  input  logic               rst,
  input  cl4_pkg::cfg_t      cfg,
  input  cl4_pkg::job_t      job,
  input  logic               job_empty,
  output logic               job_pop,
  input  logic               res_full,
  output logic               res_push,
  output cl4_pkg::res_item_t res
);
  import cl4_pkg::*;

  typedef struct packed {
    phase_t      phase;
    logic [15:0] wait_count;
    logic [3:0]  init_step;
    logic [7:0]  shift_byte;
    logic        rs_level;
    logic        en_level;
    logic [3:0]  nibble_out;
    post_gap_t   post_gap_sel;
  } seq_state_t;

  seq_state_t  st;
  seq_state_t  st_next;
  logic        go;
  logic        took;
  logic [15:0] target;
  logic [15:0] wc_inc;
  logic        hit;

  function automatic logic [7:0] init_cmd(input logic [2:0] idx);
    case (idx)
      3'd0:    init_cmd = 8'h28;
      3'd1:    init_cmd = 8'h08;
      3'd2:    init_cmd = 8'h01;
      3'd3:    init_cmd = 8'h06;
      default: init_cmd = 8'h0C;
    endcase
  endfunction

  function automatic seq_state_t start_byte(input seq_state_t s, input logic [7:0] value,
                                            input logic rs, input post_gap_t post);
    seq_state_t r;
    r              = s;
    r.shift_byte   = value;
    r.rs_level     = rs;
    r.en_level     = 1'b0;
    r.nibble_out   = value[7:4];
    r.post_gap_sel = post;
    r.wait_count   = '0;
    r.phase        = PH_SETUP_HI;
    return r;
  endfunction

  function automatic seq_state_t launch(input seq_state_t s);
    seq_state_t r;
    logic [3:0] idx;
    r   = s;
    idx = s.init_step - INIT_NIBBLES;
    if (s.init_step < INIT_NIBBLES) begin
      r.rs_level     = 1'b0;
      r.en_level     = 1'b0;
      r.nibble_out   = (s.init_step < 4'd3) ? 4'h3 : 4'h2;
      r.post_gap_sel = GAP_NONE;
      r.wait_count   = '0;
      r.phase        = PH_PRE;
    end else if (s.init_step < INIT_DONE) begin
      r = start_byte(s, init_cmd(idx[2:0]), 1'b0, GAP_INIT);
    end else begin
      r.phase = PH_IDLE;
    end
    return r;
  endfunction

  function automatic seq_state_t finish(input seq_state_t s);
    seq_state_t r;
    r            = s;
    r.wait_count = '0;
    if (s.init_step < INIT_DONE) begin
      r.init_step = s.init_step + 4'd1;
      r = launch(r);
    end else begin
      r.phase = PH_IDLE;
    end
    return r;
  endfunction

  assign go       = !job_empty && !res_full;
  assign job_pop  = go;
  assign res_push = go;

  // Wait length of the current phase.
  always_comb begin
    case (st.phase)
      PH_GAP1: begin
        if (st.init_step < INIT_NIBBLES) begin
          target = (st.init_step == 4'd0) ? cfg.first_init_gap : cfg.init_gap_ticks;
        end else begin
          target = cfg.byte_gap_ticks;
        end
      end
      PH_GAP2: target = (st.post_gap_sel == GAP_INIT) ? cfg.init_gap_ticks
                                                       : cfg.move_gap_ticks;
      default: target = cfg.setup_ticks;
    endcase
    wc_inc = st.wait_count + 16'd1;
    hit    = (wc_inc >= target) || (wc_inc == 16'd0);
  end

  // Next state.
  always_comb begin
    st_next = st;
    took    = 1'b0;
    if (st.phase == PH_START) begin
      st_next.init_step = '0;
      st_next = launch(st_next);
    end else if (st.phase == PH_IDLE && st.init_step >= INIT_DONE && job.cmd_valid) begin
      took    = 1'b1;
      st_next = start_byte(st, job.byte_value, job.rs, job.post);
    end else if (job.tick) begin
      case (st.phase)
        PH_PRE: begin
          st_next.wait_count = hit ? '0 : wc_inc;
          if (hit) begin
            st_next.phase = PH_SETUP_HI;
          end
        end
        PH_SETUP_HI: begin
          st_next.wait_count = hit ? '0 : wc_inc;
          if (hit) begin
            st_next.en_level = 1'b1;
            st_next.phase    = PH_PULSE_HI;
          end
        end
        PH_PULSE_HI: begin
          st_next.wait_count = hit ? '0 : wc_inc;
          if (hit) begin
            st_next.en_level = 1'b0;
            if (st.init_step < INIT_NIBBLES) begin
              st_next.phase = PH_GAP1;
            end else begin
              st_next.nibble_out = st.shift_byte[3:0];
              st_next.phase      = PH_SETUP_LO;
            end
          end
        end
        PH_SETUP_LO: begin
          st_next.wait_count = hit ? '0 : wc_inc;
          if (hit) begin
            st_next.en_level = 1'b1;
            st_next.phase    = PH_PULSE_LO;
          end
        end
        PH_PULSE_LO: begin
          st_next.wait_count = hit ? '0 : wc_inc;
          if (hit) begin
            st_next.en_level = 1'b0;
            st_next.phase    = PH_GAP1;
          end
        end
        PH_GAP1: begin
          st_next.wait_count = hit ? '0 : wc_inc;
          if (hit) begin
            if (st.post_gap_sel != GAP_NONE) begin
              st_next.phase = PH_GAP2;
            end else begin
              st_next = finish(st_next);
            end
          end
        end
        PH_GAP2: begin
          st_next.wait_count = hit ? '0 : wc_inc;
          if (hit) begin
            st_next = finish(st_next);
          end
        end
        default: st_next.phase = PH_IDLE;
      endcase
    end
  end

  // Result: bus levels and status after this request.
  always_comb begin
    res.rs_pin      = st_next.rs_level;
    res.en_pin      = st_next.en_level;
    res.data_nibble = st_next.nibble_out;
    res.ready_res   = (st_next.phase == PH_IDLE) && (st_next.init_step >= INIT_DONE);
    res.accepted    = took;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase        <= PH_START;
      st.wait_count   <= '0;
      st.init_step    <= '0;
      st.shift_byte   <= '0;
      st.rs_level     <= 1'b0;
      st.en_level     <= 1'b0;
      st.nibble_out   <= '0;
      st.post_gap_sel <= GAP_NONE;
    end else if (go) begin
      st <= st_next;
    end
  end

  a_en_in_pulse: assert property (@(posedge clk) disable iff (rst)
    st.en_level == (st.phase == PH_PULSE_HI || st.phase == PH_PULSE_LO))
    else $error("enable level outside a pulse phase");

  a_idle_no_count: assert property (@(posedge clk) disable iff (rst)
    (st.phase == PH_IDLE) |-> (st.wait_count == '0))
    else $error("wait counter running while idle");

  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    st.init_step <= INIT_DONE)
    else $error("power-up step out of range");

endmodule

// ----- test/tb_top.sv -----
// Self-checking testbench for char_lcd_4bit_interface: random and directed requests and ticks,
// with every LCD bus result checked against a cycle-free model of the sequencer kept here.
// Depends on cl4_pkg and the RTL of the block; reads no files.
`timescale 1ns / 100ps

module tb_top;
  import cl4_pkg::*;

  // A cycle with nothing moving on either side counts toward this limit.
  localparam int QUIET_LIMIT = 2000;
  // Length of the forced receiver hold-off that makes the block back up.
  localparam int LONG_HOLD   = 300;
  // How far the stimulus may run ahead of the driver.
  localparam int AHEAD       = 4;

  // Model of the sequencer state. One copy plans the stimulus ahead of time,
  // a second copy follows the requests the block actually takes.
  typedef struct {
    phase_t      ph;
    logic [15:0] wcnt;
    logic [3:0]  step;
    logic [7:0]  sbyte;
    logic        rs;
    logic        en;
    logic [3:0]  nib;
    post_gap_t   post;
  } lcd_state_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  in_item_t    cur_item = '0;
  logic        full;
  logic        pop = 1'b0;
  res_item_t   result;
  logic        empty;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = REG_SETUP;
  logic [15:0] cfg_data = '0;

  // Timing registers as the block holds them; reset values to start with.
  cfg_t        timing = '{setup_ticks: 16'd100, byte_gap_ticks: 16'd2000,
                          first_init_gap: 16'd5000, init_gap_ticks: 16'd1000,
                          move_gap_ticks: 16'd2000};

  lcd_state_t  plan_st;
  lcd_state_t  line_st;
  in_item_t    req_q[$];
  res_item_t   pin_q[$];
  res_item_t   want;

  int          err_cnt = 0;
  int          quiet = 0;
  int          tx_gap = 0;
  int          rx_hold = 0;
  int          hold_req = 0;
  int          hold_seen = 0;
  bit          tx_steady = 1'b0;
  bit          rx_steady = 1'b0;

  char_lcd_4bit_interface i_dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .item      (cur_item),
    .full      (full),
    .pop       (pop),
    .result    (result),
    .empty     (empty),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Sequencer model
  // ---------------------------------------------------------------------------

  function automatic lcd_state_t lcd_reset_state();
    lcd_state_t st;
    st.ph    = PH_START;
    st.wcnt  = '0;
    st.step  = '0;
    st.sbyte = '0;
    st.rs    = 1'b0;
    st.en    = 1'b0;
    st.nib   = '0;
    st.post  = GAP_NONE;
    return st;
  endfunction

  function automatic bit lcd_ready(lcd_state_t st);
    return st.ph == PH_IDLE && st.step >= INIT_DONE;
  endfunction

  // One counted tick of a wait. A target of zero ends on the first tick, and a
  // counter that wraps to zero also ends the wait.
  function automatic bit lapse(inout lcd_state_t st, input logic [15:0] target);
    st.wcnt = st.wcnt + 16'd1;
    if (st.wcnt >= target || st.wcnt == 16'd0) begin
      st.wcnt = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void load_byte(inout lcd_state_t st, input logic [7:0] value,
                                    input logic rs, input post_gap_t post);
    st.sbyte = value;
    st.rs    = rs;
    st.en    = 1'b0;
    st.nib   = value[7:4];
    st.post  = post;
    st.wcnt  = '0;
    st.ph    = PH_SETUP_HI;
  endfunction

  // Instruction bytes sent after the four bare power-up nibbles.
  function automatic logic [7:0] power_up_cmd(logic [3:0] step);
    case (step - INIT_NIBBLES)
      4'd0: return 8'h28;
      4'd1: return 8'h08;
      4'd2: return 8'h01;
      4'd3: return 8'h06;
      default: return 8'h0C;
    endcase
  endfunction

  function automatic void launch_step(inout lcd_state_t st);
    if (st.step < INIT_NIBBLES) begin
      // Bare nibble: 3 three times, then 2 to switch the display into 4-bit mode.
      st.rs   = 1'b0;
      st.en   = 1'b0;
      st.nib  = (st.step < 4'd3) ? 4'h3 : 4'h2;
      st.post = GAP_NONE;
      st.wcnt = '0;
      st.ph   = PH_PRE;
    end else if (st.step < INIT_DONE) begin
      load_byte(st, power_up_cmd(st.step), 1'b0, GAP_INIT);
    end else begin
      st.ph = PH_IDLE;
    end
  endfunction

  function automatic void finish_transfer(inout lcd_state_t st);
    st.wcnt = '0;
    if (st.step < INIT_DONE) begin
      st.step = st.step + 4'd1;
      launch_step(st);
    end else begin
      st.ph = PH_IDLE;
    end
  endfunction

  // Column and row are clamped to the display, zero counting as the first one.
  function automatic logic [7:0] cursor_cmd(logic [4:0] column, logic [2:0] row);
    int c;
    int r;
    int base;
    c = column;
    r = row;
    if (c < 1) c = 1;
    if (c > COLUMNS) c = COLUMNS;
    if (r < 1) r = 1;
    if (r > ROWS) r = ROWS;
    case (r)
      1: base = 'h00;
      2: base = 'h40;
      3: base = COLUMNS;
      default: base = 'h40 + COLUMNS;
    endcase
    return 8'h80 | 8'((base + c - 1) & 'h7F);
  endfunction

  function automatic void advance(inout lcd_state_t st);
    logic [15:0] gap;
    case (st.ph)
      PH_PRE: begin
        if (lapse(st, timing.setup_ticks)) st.ph = PH_SETUP_HI;
      end
      PH_SETUP_HI: begin
        if (lapse(st, timing.setup_ticks)) begin
          st.en = 1'b1;
          st.ph = PH_PULSE_HI;
        end
      end
      PH_PULSE_HI: begin
        if (lapse(st, timing.setup_ticks)) begin
          st.en = 1'b0;
          // Bare power-up nibbles have no low half.
          if (st.step < INIT_NIBBLES) begin
            st.ph = PH_GAP1;
          end else begin
            st.nib = st.sbyte[3:0];
            st.ph  = PH_SETUP_LO;
          end
        end
      end
      PH_SETUP_LO: begin
        if (lapse(st, timing.setup_ticks)) begin
          st.en = 1'b1;
          st.ph = PH_PULSE_LO;
        end
      end
      PH_PULSE_LO: begin
        if (lapse(st, timing.setup_ticks)) begin
          st.en = 1'b0;
          st.ph = PH_GAP1;
        end
      end
      PH_GAP1: begin
        if (st.step >= INIT_NIBBLES) gap = timing.byte_gap_ticks;
        else if (st.step == 4'd0) gap = timing.first_init_gap;
        else gap = timing.init_gap_ticks;
        if (lapse(st, gap)) begin
          if (st.post != GAP_NONE) st.ph = PH_GAP2;
          else finish_transfer(st);
        end
      end
      PH_GAP2: begin
        gap = (st.post == GAP_INIT) ? timing.init_gap_ticks : timing.move_gap_ticks;
        if (lapse(st, gap)) finish_transfer(st);
      end
      default: begin
        st.ph = PH_IDLE;
      end
    endcase
  endfunction

  // Applies one request to the model and returns the bus state that follows it.
  function automatic res_item_t lcd_step(inout lcd_state_t st, input in_item_t it);
    res_item_t r;
    logic      taken;
    taken = 1'b0;
    if (st.ph == PH_START) begin
      // The first request after reset only starts the power-up sequence.
      st.step = '0;
      launch_step(st);
    end else if (lcd_ready(st) && it.cmd_valid) begin
      // A request and a tick together: the request wins and the tick is lost.
      taken = 1'b1;
      if (it.opcode == OP_DATA) load_byte(st, it.byte_value, 1'b1, GAP_NONE);
      else if (it.opcode == OP_INSTR) load_byte(st, it.byte_value, 1'b0, GAP_NONE);
      else if (it.opcode == OP_MOVE) load_byte(st, cursor_cmd(it.column, it.row), 1'b0, GAP_MOVE);
      else load_byte(st, 8'h01, 1'b0, GAP_MOVE);
    end else if (it.tick) begin
      advance(st);
    end
    r.rs_pin      = st.rs;
    r.en_pin      = st.en;
    r.data_nibble = st.nib;
    r.ready_res   = lcd_ready(st);
    r.accepted    = taken;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver, receiver and watchdog
  // ---------------------------------------------------------------------------

  // Idle length in cycles: mostly none, sometimes a few, rarely a long one.
  function automatic int idle_len(bit steady);
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // The expected bus state is computed the moment the block takes a request;
  // the block cannot show that result before the following edge.
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) pin_q.push_back(lcd_step(line_st, cur_item));
      if (!push || !full) begin
        if (tx_gap > 0) begin
          tx_gap = tx_gap - 1;
          push <= 1'b0;
        end else if (req_q.size() != 0) begin
          cur_item <= req_q.pop_front();
          push <= 1'b1;
          tx_gap = idle_len(tx_steady);
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  task automatic field_check(input string name, input logic [7:0] exp_val,
                             input logic [7:0] got_val);
    if (exp_val !== got_val) begin
      err_cnt = err_cnt + 1;
      if (err_cnt <= 20)
        $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, exp_val, got_val);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (pin_q.size() == 0) begin
          err_cnt = err_cnt + 1;
          if (err_cnt <= 20)
            $display("%0t ns: result with no request outstanding, expected none, actual %p",
                     $time, result);
        end else begin
          want = pin_q.pop_front();
          field_check("rs_pin", want.rs_pin, result.rs_pin);
          field_check("en_pin", want.en_pin, result.en_pin);
          field_check("data_nibble", want.data_nibble, result.data_nibble);
          field_check("ready_res", want.ready_res, result.ready_res);
          field_check("accepted", want.accepted, result.accepted);
        end
      end
      // A hold-off asked for by the stimulus overrides the random stalls.
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        rx_hold = LONG_HOLD;
        pop <= 1'b0;
      end else if (rx_hold > 0) begin
        rx_hold = rx_hold - 1;
        pop <= 1'b0;
      end else begin
        rx_hold = idle_len(rx_steady);
        pop <= (rx_hold == 0);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("%0t ns: no progress for %0d cycles", $time, quiet);
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  function automatic in_item_t random_item();
    in_item_t it;
    it.tick       = 1'($urandom_range(0, 1));
    it.cmd_valid  = 1'($urandom_range(0, 1));
    it.opcode     = 2'($urandom_range(0, 3));
    it.byte_value = 8'($urandom_range(0, 255));
    it.column     = 5'($urandom_range(0, 31));
    it.row        = 3'($urandom_range(0, 7));
    return it;
  endfunction

  // Queues one request for the driver and moves the planning model past it.
  task automatic offer(input in_item_t it);
    while (req_q.size() >= AHEAD) @(negedge clk);
    void'(lcd_step(plan_st, it));
    req_q.push_back(it);
  endtask

  // Stops sending until the block has answered every request.
  task automatic settle();
    @(negedge clk);
    while (req_q.size() != 0 || push || pin_q.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  // Feeds mostly ticks, with ignored requests mixed in, until the block is idle.
  task automatic run_until_ready();
    in_item_t it;
    while (!lcd_ready(plan_st)) begin
      it = random_item();
      it.tick = ($urandom_range(0, 7) != 0);
      offer(it);
    end
  endtask

  // One request while idle, one more that must be ignored, then run it out.
  task automatic send_req(input opcode_t op, input logic [7:0] value, input logic [4:0] column,
                          input logic [2:0] row, input logic tick);
    in_item_t it;
    it = random_item();
    it.tick       = tick;
    it.cmd_valid  = 1'b1;
    it.opcode     = op;
    it.byte_value = value;
    it.column     = column;
    it.row        = row;
    offer(it);
    it = random_item();
    it.tick      = 1'b1;
    it.cmd_valid = 1'b1;
    offer(it);
    run_until_ready();
  endtask

  task automatic load_timing(input logic [15:0] setup, input logic [15:0] byte_gap,
                             input logic [15:0] first_gap, input logic [15:0] init_gap,
                             input logic [15:0] move_gap);
    settle();
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_SETUP;
    cfg_data  <= setup;
    @(posedge clk);
    cfg_index <= REG_BYTE_GAP;
    cfg_data  <= byte_gap;
    @(posedge clk);
    cfg_index <= REG_FIRST_INIT;
    cfg_data  <= first_gap;
    @(posedge clk);
    cfg_index <= REG_INIT_GAP;
    cfg_data  <= init_gap;
    @(posedge clk);
    cfg_index <= REG_MOVE_GAP;
    cfg_data  <= move_gap;
    @(posedge clk);
    cfg_we <= 1'b0;
    timing.setup_ticks    = setup;
    timing.byte_gap_ticks = byte_gap;
    timing.first_init_gap = first_gap;
    timing.init_gap_ticks = init_gap;
    timing.move_gap_ticks = move_gap;
  endtask

  // Random traffic: when the block is idle nearly every item is a request with
  // random content; while it is busy most items are ticks. Only items that the
  // block acts on count toward n.
  task automatic random_traffic(input int n);
    in_item_t it;
    int       done;
    bit       rdy;
    done = 0;
    while (done < n) begin
      rdy = lcd_ready(plan_st);
      it = random_item();
      it.tick = ($urandom_range(0, 7) != 0);
      if (rdy) it.cmd_valid = ($urandom_range(0, 9) != 0);
      else it.cmd_valid = ($urandom_range(0, 3) == 0);
      if ((rdy && it.cmd_valid) || (!rdy && it.tick)) done = done + 1;
      offer(it);
      if ($urandom_range(0, 149) == 0) tx_steady = !tx_steady;
      if ($urandom_range(0, 149) == 0) rx_steady = !rx_steady;
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  initial begin
    in_item_t it;
    plan_st = lcd_reset_state();
    line_st = lcd_reset_state();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Short waits everywhere so the power-up sequence is over quickly.
    load_timing(16'd1, 16'd1, 16'd3, 16'd2, 16'd1);

    // The very first item only starts the power-up sequence, even though it
    // carries a request and a tick.
    it = random_item();
    it.tick      = 1'b1;
    it.cmd_valid = 1'b1;
    offer(it);
    run_until_ready();

    // Idle items without a request change nothing.
    it = random_item();
    it.tick      = 1'b1;
    it.cmd_valid = 1'b0;
    offer(it);
    it.tick = 1'b0;
    offer(it);

    send_req(OP_DATA, 8'h00, 5'd0, 3'd0, 1'b1);
    send_req(OP_DATA, 8'hFF, 5'd31, 3'd7, 1'b0);
    send_req(OP_INSTR, 8'hA5, 5'd3, 3'd2, 1'b0);
    send_req(OP_INSTR, 8'h5A, 5'd12, 3'd5, 1'b1);
    // Cursor moves: zero column and row, both above range, exact limits,
    // each row base at least once.
    send_req(OP_MOVE, 8'hFF, 5'd0, 3'd0, 1'b0);
    send_req(OP_MOVE, 8'h00, 5'd31, 3'd7, 1'b1);
    send_req(OP_MOVE, 8'h3C, 5'd20, 3'd4, 1'b0);
    send_req(OP_MOVE, 8'hC3, 5'd21, 3'd2, 1'b0);
    send_req(OP_MOVE, 8'h11, 5'd1, 3'd1, 1'b0);
    send_req(OP_MOVE, 8'h22, 5'd7, 3'd3, 1'b1);
    send_req(OP_MOVE, 8'h44, 5'd0, 3'd5, 1'b0);
    send_req(OP_CLEAR, 8'hEE, 5'd9, 3'd6, 1'b0);

    // The power-up gaps are never used again, so they can sit at the top.
    load_timing(16'd3, 16'd4, 16'hFFFF, 16'hFFFF, 16'd5);
    // The receiver stops for a long stretch while requests keep coming, so the
    // block backs up and holds off the sender.
    hold_req = hold_req + 1;
    random_traffic(100);
    settle();
    random_traffic(100);

    // Zero timing registers behave like one tick.
    load_timing(16'd0, 16'd0, 16'd1, 16'd1, 16'd0);
    random_traffic(130);

    // One clear with longer waits, the counter running well past its low bits.
    tx_steady = 1'b1;
    rx_steady = 1'b1;
    load_timing(16'd8, 16'd40, 16'd1, 16'd1, 16'd40);
    send_req(OP_CLEAR, 8'h00, 5'd0, 3'd0, 1'b0);
    tx_steady = 1'b0;
    rx_steady = 1'b0;

    load_timing(16'd2, 16'd3, 16'd1, 16'd2, 16'd2);
    random_traffic(150);

    settle();
    repeat (10) @(negedge clk);
    if (err_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
